// ===== src/sfrq_pkg.sv =====
// Shared codes, types and defaults for the serial frame receiver queue.
package sfrq_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 32;

  localparam logic [7:0] SYNC_RESET = 8'd164;

  typedef logic [1:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_RECV    = 2'd0;
  localparam op_t OP_READ    = 2'd1;
  localparam op_t OP_RELEASE = 2'd2;
  localparam op_t OP_FLUSH   = 2'd3;

  localparam status_t ST_NONE      = 3'd0;
  localparam status_t ST_COMMIT    = 3'd1;
  localparam status_t ST_BAD_CHECK = 3'd2;
  localparam status_t ST_SIZE_REJ  = 3'd3;
  localparam status_t ST_RING_FULL = 3'd4;

  // Per-word response from the frame controller to the output stage.
  typedef struct packed {
    status_t status;
    logic    nonempty;
    logic    rd_zero;
  } ctrl_rsp_t;

endpackage

// ===== src/sfrq_slot_mem.sv =====
// Frame slot storage: one write port, one registered read port.
module sfrq_slot_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] store_mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/sfrq_frame_ctrl.sv =====
// Frame parser and ring pointer control; issues slot memory accesses.
module sfrq_frame_ctrl #(
  parameter int SLOT_COUNT = 4,
  parameter int SLOT_BYTES = 32,
  parameter int AW         = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_go,
  input  sfrq_pkg::op_t       op,
  input  logic [7:0]          rx_byte,
  input  logic [4:0]          read_index,
  input  logic [7:0]          sync_value,
  output sfrq_pkg::ctrl_rsp_t rsp,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr
);
  import sfrq_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW = $clog2(SLOT_BYTES + 1);
  localparam int BW = $clog2(SLOT_BYTES);

  typedef enum logic [1:0] {PH_SYNC, PH_SIZE, PH_BODY, PH_CHECK} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    check_r, check_nxt;
  logic [BW-1:0] left_r, left_nxt;
  logic [PW-1:0] wpos_r, wpos_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;

  logic [SW-1:0] head_inc, tail_inc;
  logic [PW-1:0] wpos_sel;
  logic          store_ok;
  logic          ring_busy;

  assign head_inc  = (head_r == SW'(SLOT_COUNT - 1)) ? '0 : head_r + SW'(1);
  assign tail_inc  = (tail_r == SW'(SLOT_COUNT - 1)) ? '0 : tail_r + SW'(1);
  assign ring_busy = (head_r != tail_r);
  assign wpos_sel  = (phase_r == PH_SIZE) ? '0 : wpos_r;
  assign store_ok  = (wpos_sel < PW'(SLOT_BYTES));

  assign wr_addr = AW'(head_r) * AW'(SLOT_BYTES) + AW'(wpos_sel);
  assign wr_data = rx_byte;
  assign rd_addr = AW'(tail_r) * AW'(SLOT_BYTES) + AW'(read_index);

  always_comb begin
    phase_nxt    = phase_r;
    check_nxt    = check_r;
    left_nxt     = left_r;
    wpos_nxt     = wpos_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rsp.status   = ST_NONE;
    rsp.rd_zero  = !(ring_busy && (9'(read_index) < 9'(SLOT_BYTES)));
    if (item_go) begin
      case (op)
        OP_RECV: begin
          case (phase_r)
            PH_SYNC: begin
              if (rx_byte == sync_value) begin
                phase_nxt = PH_SIZE;
                check_nxt = sync_value;
                wpos_nxt  = '0;
              end
            end
            PH_SIZE: begin
              if ({2'b00, rx_byte} + 10'd2 > 10'(SLOT_BYTES)) begin
                phase_nxt  = PH_SYNC;
                rsp.status = ST_SIZE_REJ;
              end else if (head_inc == tail_r) begin
                phase_nxt  = PH_SYNC;
                rsp.status = ST_RING_FULL;
              end else begin
                wr_en     = 1'b1;
                wpos_nxt  = PW'(1);
                check_nxt = check_r ^ rx_byte;
                left_nxt  = BW'(rx_byte);
                phase_nxt = PH_BODY;
              end
            end
            PH_BODY: begin
              wr_en     = store_ok;
              wpos_nxt  = wpos_r + PW'(1);
              check_nxt = check_r ^ rx_byte;
              if (left_r == '0) begin
                phase_nxt = PH_CHECK;
              end else begin
                left_nxt = left_r - BW'(1);
              end
            end
            default: begin
              if (rx_byte == check_r) begin
                head_nxt   = head_inc;
                rsp.status = ST_COMMIT;
              end else begin
                rsp.status = ST_BAD_CHECK;
              end
              check_nxt = '0;
              phase_nxt = PH_SYNC;
              left_nxt  = '0;
              wpos_nxt  = '0;
            end
          endcase
        end
        OP_READ: begin
          rd_en = 1'b1;
        end
        OP_RELEASE: begin
          if (ring_busy) begin
            tail_nxt = tail_inc;
          end
        end
        default: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          phase_nxt = PH_SYNC;
          check_nxt = '0;
          left_nxt  = '0;
          wpos_nxt  = '0;
        end
      endcase
    end
    rsp.nonempty = (head_nxt != tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      check_r <= '0;
      left_r  <= '0;
      wpos_r  <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      check_r <= check_nxt;
      left_r  <= left_nxt;
      wpos_r  <= wpos_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

// ===== src/serial_frame_receiver_queue_core.sv =====
// Top level of the serial frame receiver queue: handshakes, config, output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready   | in_op, in_rx_byte, in_read_index
//  out     | output    | out_valid / out_ready | out_read_data, out_frame_status,
//          |           |                      | out_queue_nonempty
//  cfg     | input     | cfg_we (no wait)     | cfg_wdata (sync byte)
//
// Receive, release and flush words finish in the cycle they are accepted: their
// result is loaded into the output register at that edge. A read word passes the
// registered read port of the slot memory first; in_ready drops for the cycle in
// which the read data returns. A new word is taken whenever no read is pending
// and the output register is empty or being drained at the same edge, so a
// waiting result never blocks the input by more than that. Reset is synchronous,
// active low; it clears pointers, parser state and the sync byte (to 164). The
// slot memory has no reset and needs no clearing pass.
module serial_frame_receiver_queue_core #(
  parameter int SLOT_COUNT = sfrq_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = sfrq_pkg::SLOT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfrq_pkg::op_t       in_op,
  input  logic [7:0]          in_rx_byte,
  input  logic [4:0]          in_read_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_read_data,
  output sfrq_pkg::status_t   out_frame_status,
  output logic                out_queue_nonempty,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import sfrq_pkg::*;

  localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]  sync_r;
  logic        accept;
  logic        is_read;
  ctrl_rsp_t   rsp;
  logic        wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]  wr_data, rd_data;

  // Read in flight and what to return with it.
  logic        rd_pend_r, rd_pend_nxt;
  logic        rd_zero_r;
  logic        rd_nonempty_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  status_t     out_status_r;
  logic        out_nonempty_r;

  assign in_ready = !rd_pend_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_read  = (in_op == OP_READ);

  sfrq_frame_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (accept),
    .op         (in_op),
    .rx_byte    (in_rx_byte),
    .read_index (in_read_index),
    .sync_value (sync_r),
    .rsp        (rsp),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  sfrq_slot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Fill the output register on a non-read word or on read data return;
  // drop it once taken.
  assign rd_pend_nxt   = accept && is_read;
  assign out_valid_nxt = (out_valid_r && !out_ready) || rd_pend_r || (accept && !is_read);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= SYNC_RESET;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sync_r <= cfg_wdata;
      end
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold read context, load results.
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      rd_zero_r     <= rsp.rd_zero;
      rd_nonempty_r <= rsp.nonempty;
    end
    if (rd_pend_r) begin
      out_data_r     <= rd_zero_r ? 8'd0 : rd_data;
      out_status_r   <= ST_NONE;
      out_nonempty_r <= rd_nonempty_r;
    end else if (accept && !is_read) begin
      out_data_r     <= 8'd0;
      out_status_r   <= rsp.status;
      out_nonempty_r <= rsp.nonempty;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_frame_status   = out_status_r;
  assign out_queue_nonempty = out_nonempty_r;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the serial frame receiver queue core.
`timescale 1ns / 1ps

module tb;
  import sfrq_pkg::*;

  localparam int SLOT_COUNT = SLOT_COUNT_DEF;
  localparam int SLOT_BYTES = SLOT_BYTES_DEF;
  // Longest legal quiet stretch is a sender gap plus a receiver stall plus the
  // read latency and the idle time around a sync-byte write; allow far more.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS = 100;

  typedef enum logic [1:0] {P_HUNT, P_SIZE, P_BODY, P_CSUM} parse_t;

  // One word for the input channel; gap is the idle cycles placed before it.
  typedef struct {
    op_t        op;
    logic [7:0] rx;
    logic [4:0] idx;
    int         gap;
  } word_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       nonempty;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  op_t        in_op = OP_RECV;
  logic [7:0] in_rx_byte = 8'd0;
  logic [4:0] in_read_index = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  status_t    out_frame_status;
  logic       out_queue_nonempty;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  serial_frame_receiver_queue_core #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_data(out_read_data),
    .out_frame_status(out_frame_status),
    .out_queue_nonempty(out_queue_nonempty),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the block: sync byte, parser, ring pointers and slot bytes, all but
  // the slot bytes (zeroed) starting from their reset values.
  logic [7:0] sync_byte = SYNC_RESET;
  parse_t     parse_ph = P_HUNT;
  logic [7:0] run_xor = 8'd0;
  logic [4:0] left_cnt = 5'd0;
  int         wr_pos = 0;
  int         head_slot = 0;
  int         tail_slot = 0;
  logic [7:0] slot_mem [SLOT_COUNT*SLOT_BYTES] = '{default: 8'd0};

  word_t   pending_words[$];
  result_t awaited_results[$];

  int errors = 0;
  int words_made = 0;
  int words_taken = 0;
  int reads_taken = 0;
  int sync_settings = 1;
  int status_seen [5] = '{default: 0};
  int in_calm = 0;
  int out_calm = 0;
  int idle_ticks = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Draw a pause, often none; now and then start a stretch of no pauses.
  function automatic int pick_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Write one byte into the slot being filled; positions past the slot drop.
  function automatic void stash(logic [7:0] b);
    if (wr_pos < SLOT_BYTES)
      slot_mem[head_slot*SLOT_BYTES + wr_pos] = b;
    wr_pos++;
  endfunction

  // Advance the shadow by one accepted word and return the result it causes.
  function automatic result_t step_frame_ring(op_t op, logic [7:0] rx, logic [4:0] idx);
    result_t r;
    r = '0;
    case (op)
      OP_RECV: begin
        case (parse_ph)
          P_HUNT: begin
            if (rx == sync_byte) begin
              parse_ph = P_SIZE;
              run_xor = sync_byte;
              wr_pos = 0;
            end
          end
          P_SIZE: begin
            if (int'(rx) + 2 > SLOT_BYTES) begin
              parse_ph = P_HUNT;
              r.status = ST_SIZE_REJ;
            end else if ((head_slot + 1) % SLOT_COUNT == tail_slot) begin
              parse_ph = P_HUNT;
              r.status = ST_RING_FULL;
            end else begin
              wr_pos = 0;
              stash(rx);
              run_xor ^= rx;
              left_cnt = rx[4:0];
              parse_ph = P_BODY;
            end
          end
          P_BODY: begin
            stash(rx);
            run_xor ^= rx;
            if (left_cnt == 5'd0)
              parse_ph = P_CSUM;
            else
              left_cnt--;
          end
          default: begin
            if (rx == run_xor) begin
              head_slot = (head_slot + 1) % SLOT_COUNT;
              r.status = ST_COMMIT;
            end else begin
              r.status = ST_BAD_CHECK;
            end
            run_xor = 8'd0;
            parse_ph = P_HUNT;
            left_cnt = 5'd0;
            wr_pos = 0;
          end
        endcase
      end
      OP_READ: begin
        if (head_slot != tail_slot && int'(idx) < SLOT_BYTES)
          r.data = slot_mem[tail_slot*SLOT_BYTES + int'(idx)];
      end
      OP_RELEASE: begin
        if (head_slot != tail_slot)
          tail_slot = (tail_slot + 1) % SLOT_COUNT;
      end
      default: begin
        head_slot = 0;
        tail_slot = 0;
        parse_ph = P_HUNT;
        run_xor = 8'd0;
        left_cnt = 5'd0;
        wr_pos = 0;
      end
    endcase
    r.nonempty = (head_slot != tail_slot);
    return r;
  endfunction

  function automatic void add_word(op_t op, logic [7:0] rx, logic [4:0] idx);
    word_t w;
    w.op = op;
    w.rx = rx;
    w.idx = idx;
    w.gap = pick_pause(in_calm);
    pending_words.push_back(w);
    words_made++;
  endfunction

  // Queue a whole frame under the current sync byte. With use_fixed every
  // id and data byte is fixed; with bad the checksum byte is corrupted.
  function automatic void add_frame(logic [7:0] size, bit bad, bit use_fixed,
                                    logic [7:0] fixed);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sync_byte ^ size;
    add_word(OP_RECV, sync_byte, 5'($urandom));
    add_word(OP_RECV, size, 5'($urandom));
    for (int i = 0; i <= int'(size); i++) begin
      b = use_fixed ? fixed : 8'($urandom);
      sum ^= b;
      add_word(OP_RECV, b, 5'($urandom));
    end
    if (bad)
      sum ^= 8'($urandom_range(1, 255));
    add_word(OP_RECV, sum, 5'($urandom));
  endfunction

  // Mostly short frames so reads and releases stay frequent; a few reach the
  // largest size that still fits a slot.
  function automatic logic [7:0] pick_size();
    if ($urandom_range(0, 15) == 0)
      return 8'(SLOT_BYTES - 2);
    if ($urandom_range(0, 5) == 0)
      return 8'($urandom_range(0, SLOT_BYTES - 2));
    return 8'($urandom_range(0, 6));
  endfunction

  task automatic fill_random(int target);
    int goal;
    int pick;
    logic [7:0] s;
    int k;
    goal = words_made + target;
    @(negedge clk);
    while (words_made < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        add_frame(pick_size(), $urandom_range(0, 9) == 0, 1'b0, 8'd0);
      end else if (pick < 62) begin
        add_word(OP_READ, 8'($urandom), 5'($urandom));
      end else if (pick < 80) begin
        add_word(OP_RELEASE, 8'($urandom), 5'($urandom));
      end else if (pick < 83) begin
        add_word(OP_FLUSH, 8'($urandom), 5'($urandom));
      end else if (pick < 89) begin
        // Line noise; the parser mostly ignores it, so keep it off the count.
        add_word(OP_RECV, ($urandom_range(0, 3) == 0) ? sync_byte : 8'($urandom),
                 5'($urandom));
        words_made--;
      end else if (pick < 94) begin
        add_word(OP_RECV, sync_byte, 5'($urandom));
        add_word(OP_RECV, 8'($urandom_range(SLOT_BYTES - 1, 255)), 5'($urandom));
      end else begin
        // Cut a frame short; the following bytes land in its body.
        s = pick_size();
        k = $urandom_range(0, int'(s));
        add_word(OP_RECV, sync_byte, 5'($urandom));
        add_word(OP_RECV, s, 5'($urandom));
        for (int i = 0; i < k; i++)
          add_word(OP_RECV, 8'($urandom), 5'($urandom));
        if ($urandom_range(0, 2) == 0)
          add_word(OP_FLUSH, 8'($urandom), 5'($urandom));
      end
    end
  endtask

  // Block until every queued word is taken and every result checked.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_sync(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sync_byte = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_settings++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: take the accepted word into the shadow, then present the next one
  // after its gap. Hold valid and payload until the handshake completes.
  always @(posedge clk) begin : drive
    word_t   w;
    result_t r;
    logic    fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_ticks <= 0;
    end else begin
      if (fire) begin
        r = step_frame_ring(in_op, in_rx_byte, in_read_index);
        awaited_results.push_back(r);
        words_taken++;
        if (in_op == OP_READ)
          reads_taken++;
      end
      if (!in_valid || fire) begin
        if (pending_words.size() != 0 && idle_ticks >= pending_words[0].gap) begin
          w = pending_words.pop_front();
          // Keep reads inside the oldest frame; bytes past its length are
          // stale leftovers and must not be read.
          if (w.op == OP_READ && head_slot != tail_slot)
            w.idx = 5'(int'(w.idx) % (int'(slot_mem[tail_slot*SLOT_BYTES]) + 2));
          in_op <= w.op;
          in_rx_byte <= w.rx;
          in_read_index <= w.idx;
          in_valid <= 1'b1;
          idle_ticks <= 0;
        end else begin
          in_valid <= 1'b0;
          if (pending_words.size() != 0)
            idle_ticks <= idle_ticks + 1;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // drop ready for a drawn number of cycles.
  always @(posedge clk) begin : observe
    result_t want;
    int      n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, got data %0d status %0d nonempty %0d",
                   $time, out_read_data, out_frame_status, out_queue_nonempty);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("read_data", want.data, out_read_data);
          check_field("frame_status", 8'(want.status), 8'(out_frame_status));
          check_field("queue_nonempty", 8'(want.nonempty), 8'(out_queue_nonempty));
          status_seen[want.status]++;
        end
        n = pick_pause(out_calm);
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold_left <= n;
        end
      end else if (!out_ready) begin
        if (hold_left <= 1) begin
          out_ready <= 1'b1;
          hold_left <= 0;
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, awaited_results.size());
      $display("serial_frame_receiver_queue_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass under the reset sync byte.
    @(negedge clk);
    add_word(OP_READ, 8'($urandom), 5'd31);          // read from an empty ring
    add_word(OP_RELEASE, 8'($urandom), 5'($urandom)); // release of an empty ring
    add_frame(8'd0, 1'b0, 1'b1, 8'hFF);              // shortest frame, id all ones
    add_word(OP_READ, 8'($urandom), 5'd0);
    add_word(OP_READ, 8'($urandom), 5'd1);
    add_word(OP_RECV, sync_byte, 5'($urandom));      // size one past the slot limit
    add_word(OP_RECV, 8'(SLOT_BYTES - 1), 5'($urandom));
    add_frame(8'd0, 1'b1, 1'b1, 8'h00);              // bad checksum
    add_frame(8'd1, 1'b0, 1'b1, 8'h00);
    add_frame(8'd0, 1'b0, 1'b1, 8'h5A);              // ring now holds its maximum
    add_word(OP_RECV, sync_byte, 5'($urandom));      // no free slot: frame dropped
    add_word(OP_RECV, 8'd0, 5'($urandom));
    add_word(OP_RELEASE, 8'($urandom), 5'($urandom));
    add_word(OP_READ, 8'($urandom), 5'd2);
    add_word(OP_RECV, sync_byte, 5'($urandom));      // flush in the middle of a frame
    add_word(OP_RECV, 8'd4, 5'($urandom));
    add_word(OP_FLUSH, 8'($urandom), 5'($urandom));
    add_word(OP_READ, 8'($urandom), 5'd17);

    fill_random(PHASE_WORDS);
    wait_idle();

    // Walk the sync byte through its extremes, a random value, and a value
    // that is also a legal frame size.
    set_sync(8'h00);
    fill_random(PHASE_WORDS);
    wait_idle();
    set_sync(8'hFF);
    fill_random(PHASE_WORDS);
    wait_idle();
    set_sync(8'($urandom));
    fill_random(PHASE_WORDS);
    wait_idle();
    set_sync(8'd12);
    fill_random(PHASE_WORDS);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("Ran %0d words (%0d reads) under %0d sync settings.",
             words_taken, reads_taken, sync_settings);
    $display("Frames: %0d committed, %0d bad checksum, %0d size rejected, %0d dropped full.",
             status_seen[ST_COMMIT], status_seen[ST_BAD_CHECK],
             status_seen[ST_SIZE_REJ], status_seen[ST_RING_FULL]);
    if (errors == 0) begin
      $display("serial_frame_receiver_queue_core regression: pass");
    end else begin
      $display("serial_frame_receiver_queue_core regression: fail");
    end
    $finish;
  end

endmodule
